// ----- hdl/spot_pkg.sv -----
// Shared types for the shape pair overlap tester.
// Pair kind codes and the control group passed from operand selection to the result logic.
// No dependencies.
`timescale 1ns / 1ps

package spot_pkg;

  typedef enum logic [2:0] {
    REQ_PT_CIRC   = 3'd0,
    REQ_PT_BOX    = 3'd1,
    REQ_CIRC_CIRC = 3'd2,
    REQ_CIRC_BOX  = 3'd3,
    REQ_BOX_BOX   = 3'd4
  } req_kind_e;

  // dist_en: answer comes from the squared distance compare
  // rect_hit: answer of the interval tests when dist_en is low
  typedef struct packed {
    logic dist_en;
    logic rect_hit;
  } spot_ctrl_t;

endpackage

// ----- hdl/spot_operand_sel.sv -----
// Operand selection for the overlap tester: box extents, interval tests and
// the deltas and radius for the one distance test a request needs.
// Depends on spot_pkg.
`timescale 1ns / 1ps

module spot_operand_sel #(
  parameter int COORD_BITS = 16
) (
  input  spot_pkg::req_kind_e         kind_i,
  input  logic signed [COORD_BITS-1:0] a_x_i,
  input  logic signed [COORD_BITS-1:0] a_y_i,
  input  logic [COORD_BITS-2:0]        a_radius_i,
  input  logic [COORD_BITS-2:0]        a_width_i,
  input  logic [COORD_BITS-2:0]        a_height_i,
  input  logic signed [COORD_BITS-1:0] b_x_i,
  input  logic signed [COORD_BITS-1:0] b_y_i,
  input  logic [COORD_BITS-2:0]        b_radius_i,
  input  logic [COORD_BITS-2:0]        b_width_i,
  input  logic [COORD_BITS-2:0]        b_height_i,
  output logic [COORD_BITS:0]          dx_o,
  output logic [COORD_BITS:0]          dy_o,
  output logic [COORD_BITS-1:0]        radius_o,
  output spot_pkg::spot_ctrl_t         ctrl_o
);
  import spot_pkg::*;

  localparam int EW = COORD_BITS + 3;

  function automatic logic [COORD_BITS:0] abs_diff(input logic signed [EW-1:0] p,
                                                   input logic signed [EW-1:0] q);
    logic signed [EW-1:0] d;
    d = p - q;
    if (d < 0) begin
      d = -d;
    end
    return d[COORD_BITS:0];
  endfunction

  logic signed [EW-1:0] ax, ay, bx, by, ar, ahw, ahh, bhw, bhh;
  logic signed [EW-1:0] bminx, bmaxx, bminy, bmaxy;
  logic                 in_xband, in_yband, grown_hit, box_hit;
  logic signed [EW-1:0] corner_x, corner_y;

  assign ax  = EW'(a_x_i);
  assign ay  = EW'(a_y_i);
  assign bx  = EW'(b_x_i);
  assign by  = EW'(b_y_i);
  assign ar  = signed'(EW'(a_radius_i));
  assign ahw = signed'(EW'(a_width_i >> 1));
  assign ahh = signed'(EW'(a_height_i >> 1));
  assign bhw = signed'(EW'(b_width_i >> 1));
  assign bhh = signed'(EW'(b_height_i >> 1));

  assign bminx = bx - bhw;
  assign bmaxx = bx + bhw;
  assign bminy = by - bhh;
  assign bmaxy = by + bhh;

  assign in_xband  = (bminx <= ax) && (ax <= bmaxx);
  assign in_yband  = (bminy <= ay) && (ay <= bmaxy);
  assign grown_hit = (bminx - ar <= ax) && (ax <= bmaxx + ar) &&
                     (bminy - ar <= ay) && (ay <= bmaxy + ar);
  assign box_hit   = (ax - ahw <= bmaxx) && (bminx <= ax + ahw) &&
                     (ay - ahh <= bmaxy) && (bminy <= ay + ahh);

  // Outside both bands the nearest corner is closest on both axes, so if any
  // corner lies in the circle this one does.
  assign corner_x = (ax < bminx) ? bminx : bmaxx;
  assign corner_y = (ay < bminy) ? bminy : bmaxy;

  always_comb begin
    dx_o   = abs_diff(ax, bx);
    dy_o   = abs_diff(ay, by);
    radius_o = COORD_BITS'(b_radius_i);
    ctrl_o = '0;
    case (kind_i)
      REQ_PT_CIRC: begin
        ctrl_o.dist_en = 1'b1;
      end
      REQ_PT_BOX: begin
        ctrl_o.rect_hit = in_xband && in_yband;
      end
      REQ_CIRC_CIRC: begin
        ctrl_o.dist_en = 1'b1;
        radius_o = COORD_BITS'(a_radius_i) + COORD_BITS'(b_radius_i);
      end
      REQ_CIRC_BOX: begin
        radius_o = COORD_BITS'(a_radius_i);
        if (in_xband || in_yband) begin
          ctrl_o.rect_hit = grown_hit;
        end else begin
          ctrl_o.dist_en = 1'b1;
          dx_o = abs_diff(corner_x, ax);
          dy_o = abs_diff(corner_y, ay);
        end
      end
      REQ_BOX_BOX: begin
        ctrl_o.rect_hit = box_hit;
      end
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

endmodule

// ----- hdl/spot_dist_cmp.sv -----
// Exact squared distance compare: dx*dx + dy*dy <= r*r, merged with the
// interval result to form the hit bit. Depends on spot_pkg.
`timescale 1ns / 1ps

module spot_dist_cmp #(
  parameter int COORD_BITS = 16
) (
  input  logic [COORD_BITS:0]   dx_i,
  input  logic [COORD_BITS:0]   dy_i,
  input  logic [COORD_BITS-1:0] radius_i,
  input  spot_pkg::spot_ctrl_t  ctrl_i,
  output logic                  hit_o
);
  import spot_pkg::*;

  localparam int SW = 2 * COORD_BITS + 3;

  logic [2*COORD_BITS+1:0] dx_sq, dy_sq;
  logic [2*COORD_BITS-1:0] r_sq;
  logic [SW-1:0]           d_sq;

  assign dx_sq = dx_i * dx_i;
  assign dy_sq = dy_i * dy_i;
  assign r_sq  = radius_i * radius_i;
  assign d_sq  = SW'(dx_sq) + SW'(dy_sq);

  assign hit_o = ctrl_i.rect_hit || (ctrl_i.dist_en && (d_sq <= SW'(r_sq)));

endmodule

// ----- hdl/shape_pair_overlap_test.sv -----
// Shape pair overlap tester: point, circle and axis-aligned box pairs.
// Request channel: req_type_i selects the pair kind, a_* and b_* carry the
//   two shapes (signed fixed point coordinates, unsigned radius and full
//   extents). A request is taken on a clock edge with in_valid_i high and
//   in_stall_o low.
// Result channel: hit_o is taken on an edge with out_valid_o high and
//   out_stall_i low. Every request gives exactly one result, in order.
// Order: a taken request is held in the request register, then its result
//   is loaded into the result register. Throughput: one request per cycle while
//   out_stall_i is low. Operand selection and one squared-distance compare (three
//   multipliers, two of COORD_BITS+1 bits and one of COORD_BITS) lie between them.
// Stall: while a result waits, one more request is held in the request
//   register; in_stall_o rises only when both registers are full and
//   out_stall_i is high.
// Reset: rst_ni clears both valid flags; no result is pending afterward.
// Unknown pair kinds give hit_o = 0.
// Depends on spot_pkg, spot_operand_sel and spot_dist_cmp.
`timescale 1ns / 1ps

module shape_pair_overlap_test #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   req_type_i,
  input  logic signed [COORD_BITS-1:0] a_x_i,
  input  logic signed [COORD_BITS-1:0] a_y_i,
  input  logic [COORD_BITS-2:0]        a_radius_i,
  input  logic [COORD_BITS-2:0]        a_width_i,
  input  logic [COORD_BITS-2:0]        a_height_i,
  input  logic signed [COORD_BITS-1:0] b_x_i,
  input  logic signed [COORD_BITS-1:0] b_y_i,
  input  logic [COORD_BITS-2:0]        b_radius_i,
  input  logic [COORD_BITS-2:0]        b_width_i,
  input  logic [COORD_BITS-2:0]        b_height_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o
);
  import spot_pkg::*;

  logic                         req_valid_q, req_valid_d;
  logic [2:0]                   req_type_q;
  logic signed [COORD_BITS-1:0] a_x_q, a_y_q, b_x_q, b_y_q;
  logic [COORD_BITS-2:0]        a_radius_q, a_width_q, a_height_q;
  logic [COORD_BITS-2:0]        b_radius_q, b_width_q, b_height_q;
  logic                         out_valid_q, out_valid_d;
  logic                         hit_q, hit_d;
  logic                         out_ready, req_load;

  logic [COORD_BITS:0]   dx, dy;
  logic [COORD_BITS-1:0] radius;
  spot_ctrl_t            ctrl;

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = req_valid_q && !out_ready;
  assign req_load    = in_valid_i && !in_stall_o;
  assign req_valid_d = in_stall_o ? req_valid_q : in_valid_i;
  assign out_valid_d = out_ready ? req_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the request while the result register is blocked.
  always_ff @(posedge clk_i) begin
    if (req_load) begin
      req_type_q <= req_type_i;
      a_x_q      <= a_x_i;
      a_y_q      <= a_y_i;
      a_radius_q <= a_radius_i;
      a_width_q  <= a_width_i;
      a_height_q <= a_height_i;
      b_x_q      <= b_x_i;
      b_y_q      <= b_y_i;
      b_radius_q <= b_radius_i;
      b_width_q  <= b_width_i;
      b_height_q <= b_height_i;
    end
    if (out_ready && req_valid_q) begin
      hit_q <= hit_d;
    end
  end

  spot_operand_sel #(
    .COORD_BITS(COORD_BITS)
  ) u_operand_sel (
    .kind_i     (req_kind_e'(req_type_q)),
    .a_x_i      (a_x_q),
    .a_y_i      (a_y_q),
    .a_radius_i (a_radius_q),
    .a_width_i  (a_width_q),
    .a_height_i (a_height_q),
    .b_x_i      (b_x_q),
    .b_y_i      (b_y_q),
    .b_radius_i (b_radius_q),
    .b_width_i  (b_width_q),
    .b_height_i (b_height_q),
    .dx_o       (dx),
    .dy_o       (dy),
    .radius_o   (radius),
    .ctrl_o     (ctrl)
  );

  spot_dist_cmp #(
    .COORD_BITS(COORD_BITS)
  ) u_dist_cmp (
    .dx_i     (dx),
    .dy_i     (dy),
    .radius_i (radius),
    .ctrl_i   (ctrl),
    .hit_o    (hit_d)
  );

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;

`ifndef SYNTHESIS
  a_req_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && out_valid_q && out_stall_i) |=> req_valid_q)
    else $error("pending request dropped while result stalled");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && out_ready) |=> out_valid_q)
    else $error("request advanced without producing a result");

  a_unknown_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && out_ready && (req_type_q > 3'(REQ_BOX_BOX))) |=> !hit_q)
    else $error("unknown pair kind reported a hit");

  a_one_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q |-> !(ctrl.dist_en && ctrl.rect_hit))
    else $error("distance and interval answers both selected");
`endif

endmodule
